FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, masked while in reset
`define CNC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("cavlc_nc assertion failed");

// implication checked in the next cycle, masked while in reset
`define CNC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("cavlc_nc assertion failed");

// implication checked in the next cycle, active during reset too
`define CNC_ASSERT_NXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("cavlc_nc assertion failed");

`endif

FILE: rtl/cavlc_nc_pkg.sv
package cavlc_nc_pkg;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_RECORD = 2'd2;

  localparam logic [1:0] BT_LUMA_DC   = 2'd0;
  localparam logic [1:0] BT_LUMA      = 2'd1;
  localparam logic [1:0] BT_CHROMA_DC = 2'd2;
  localparam logic [1:0] BT_CHROMA_AC = 2'd3;

  localparam int IN_DATA_W  = 104;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 16;

  typedef logic [4:0] count_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  block_type;
    logic [3:0]  block_index;
    logic        intra_mb;
    logic        left_available;
    logic        top_available;
    count_t      coeff_cnt;
    logic [19:0] left_luma_counts;
    logic [19:0] top_luma_counts;
    logic [39:0] chroma_neighbor_counts;
    logic [7:0]  neighbor_dc_flags;
  } item_t;

  typedef struct packed {
    count_t [15:0] luma;
    count_t [7:0]  chroma;
    count_t [3:0]  left_luma;
    count_t [3:0]  top_luma;
    count_t [7:0]  chroma_nb;
    logic [7:0]    nb_dc;
  } state_t;

  typedef struct packed {
    logic              coded_flag_left;
    logic              coded_flag_top;
    logic signed [5:0] predicted_count;
  } query_t;

  // neighbour sources: below 16 a block of this macroblock, 16 and up neighbour slot
  localparam logic [4:0] LUMA_LEFT_SRC [16] = '{
    5'd16, 5'd0, 5'd17, 5'd2, 5'd1, 5'd4, 5'd3, 5'd6,
    5'd18, 5'd8, 5'd19, 5'd10, 5'd9, 5'd12, 5'd11, 5'd14
  };
  localparam logic [4:0] LUMA_TOP_SRC [16] = '{
    5'd16, 5'd17, 5'd0, 5'd1, 5'd18, 5'd19, 5'd4, 5'd5,
    5'd2, 5'd3, 5'd8, 5'd9, 5'd6, 5'd7, 5'd12, 5'd13
  };
  // chroma: below 4 a block of this component, 4 and up neighbour slot
  localparam logic [2:0] CHROMA_LEFT_SRC [4] = '{3'd4, 3'd0, 3'd5, 3'd2};
  localparam logic [2:0] CHROMA_TOP_SRC  [4] = '{3'd6, 3'd7, 3'd0, 3'd1};

  function automatic count_t mean_nc(input logic la, input logic ta,
                                     input count_t na, input count_t nb);
    logic [5:0] s;
    s = {1'b0, na} + {1'b0, nb} + 6'd1;
    if (la && ta) return s[5:1];
    else if (la)  return na;
    else if (ta)  return nb;
    else          return '0;
  endfunction

endpackage

FILE: rtl/cavlc_nc_store.sv
module cavlc_nc_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd_en,
  input  cavlc_nc_pkg::item_t  item,
  output cavlc_nc_pkg::state_t state,
  output logic [2:0]           dc_nxt
);

  cavlc_nc_pkg::count_t [15:0] luma_r, luma_nxt;
  cavlc_nc_pkg::count_t [7:0]  chroma_r, chroma_nxt;
  cavlc_nc_pkg::count_t [3:0]  left_r, left_nxt;
  cavlc_nc_pkg::count_t [3:0]  top_r, top_nxt;
  cavlc_nc_pkg::count_t [7:0]  chroma_nb_r, chroma_nb_nxt;
  logic [7:0]                  nb_dc_r, nb_dc_nxt;
  logic [2:0]                  dc_r;
  logic                        tc_nz;
  logic                        cr_sel;

  always_comb begin
    luma_nxt      = luma_r;
    chroma_nxt    = chroma_r;
    left_nxt      = left_r;
    top_nxt       = top_r;
    chroma_nb_nxt = chroma_nb_r;
    nb_dc_nxt     = nb_dc_r;
    dc_nxt        = dc_r;
    tc_nz         = |item.coeff_cnt;
    cr_sel        = item.block_index[3] | item.block_index[2];
    unique case (item.command)
      cavlc_nc_pkg::CMD_START: begin
        left_nxt      = item.left_luma_counts;
        top_nxt       = item.top_luma_counts;
        chroma_nb_nxt = item.chroma_neighbor_counts;
        nb_dc_nxt     = item.neighbor_dc_flags;
        luma_nxt      = '0;
        chroma_nxt    = '0;
        dc_nxt        = '0;
      end
      cavlc_nc_pkg::CMD_RECORD: begin
        unique case (item.block_type)
          cavlc_nc_pkg::BT_LUMA_DC: begin
            if (tc_nz) dc_nxt[0] = 1'b1;
          end
          cavlc_nc_pkg::BT_CHROMA_DC: begin
            if (tc_nz) begin
              if (|item.block_index) dc_nxt[2] = 1'b1;
              else                   dc_nxt[1] = 1'b1;
            end
          end
          cavlc_nc_pkg::BT_LUMA: begin
            luma_nxt[item.block_index] = item.coeff_cnt;
          end
          default: begin
            chroma_nxt[{cr_sel, item.block_index[1:0]}] = item.coeff_cnt;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luma_r      <= '0;
      chroma_r    <= '0;
      left_r      <= '0;
      top_r       <= '0;
      chroma_nb_r <= '0;
      nb_dc_r     <= '0;
      dc_r        <= '0;
    end else if (upd_en) begin
      luma_r      <= luma_nxt;
      chroma_r    <= chroma_nxt;
      left_r      <= left_nxt;
      top_r       <= top_nxt;
      chroma_nb_r <= chroma_nb_nxt;
      nb_dc_r     <= nb_dc_nxt;
      dc_r        <= dc_nxt;
    end
  end

  assign state.luma      = luma_r;
  assign state.chroma    = chroma_r;
  assign state.left_luma = left_r;
  assign state.top_luma  = top_r;
  assign state.chroma_nb = chroma_nb_r;
  assign state.nb_dc     = nb_dc_r;

endmodule

FILE: rtl/cavlc_nc_pred.sv
module cavlc_nc_pred (
  input  cavlc_nc_pkg::item_t  item,
  input  cavlc_nc_pkg::state_t state,
  output cavlc_nc_pkg::query_t res
);

  cavlc_nc_pkg::count_t luma_l_cnt [16];
  cavlc_nc_pkg::count_t luma_t_cnt [16];
  logic                 luma_l_ext [16];
  logic                 luma_t_ext [16];
  cavlc_nc_pkg::count_t chr_l_cnt [8];
  cavlc_nc_pkg::count_t chr_t_cnt [8];
  logic                 chr_l_ext [4];
  logic                 chr_t_ext [4];

  logic [3:0]           blk;
  logic [2:0]           slot;
  logic                 cr_ac;
  logic                 cr_dc;
  logic                 la, ta;
  cavlc_nc_pkg::count_t na, nb;

  // neighbour candidates per block, wired from fixed places in the store
  always_comb begin
    for (int b = 0; b < 16; b++) begin
      luma_l_ext[b] = cavlc_nc_pkg::LUMA_LEFT_SRC[b][4];
      luma_t_ext[b] = cavlc_nc_pkg::LUMA_TOP_SRC[b][4];
      luma_l_cnt[b] = luma_l_ext[b] ?
                      state.left_luma[cavlc_nc_pkg::LUMA_LEFT_SRC[b][1:0]] :
                      state.luma[cavlc_nc_pkg::LUMA_LEFT_SRC[b][3:0]];
      luma_t_cnt[b] = luma_t_ext[b] ?
                      state.top_luma[cavlc_nc_pkg::LUMA_TOP_SRC[b][1:0]] :
                      state.luma[cavlc_nc_pkg::LUMA_TOP_SRC[b][3:0]];
    end
    for (int s = 0; s < 4; s++) begin
      chr_l_ext[s] = cavlc_nc_pkg::CHROMA_LEFT_SRC[s][2];
      chr_t_ext[s] = cavlc_nc_pkg::CHROMA_TOP_SRC[s][2];
    end
    for (int c = 0; c < 2; c++) begin
      for (int s = 0; s < 4; s++) begin
        chr_l_cnt[c*4+s] = chr_l_ext[s] ?
          state.chroma_nb[c*4 + cavlc_nc_pkg::CHROMA_LEFT_SRC[s][1:0]] :
          state.chroma[c*4 + cavlc_nc_pkg::CHROMA_LEFT_SRC[s][1:0]];
        chr_t_cnt[c*4+s] = chr_t_ext[s] ?
          state.chroma_nb[c*4 + cavlc_nc_pkg::CHROMA_TOP_SRC[s][1:0]] :
          state.chroma[c*4 + cavlc_nc_pkg::CHROMA_TOP_SRC[s][1:0]];
      end
    end
  end

  always_comb begin
    cr_ac = item.block_index[3] | item.block_index[2];
    cr_dc = |item.block_index;
    slot  = {cr_ac, item.block_index[1:0]};
    blk   = (item.block_type == cavlc_nc_pkg::BT_LUMA_DC) ? 4'd0 : item.block_index;
    la    = 1'b0;
    ta    = 1'b0;
    na    = '0;
    nb    = '0;
    res   = '0;
    unique case (item.block_type)
      cavlc_nc_pkg::BT_CHROMA_DC: begin
        res.coded_flag_left = item.left_available ?
                              (cr_dc ? state.nb_dc[2] : state.nb_dc[1]) : item.intra_mb;
        res.coded_flag_top  = item.top_available ?
                              (cr_dc ? state.nb_dc[6] : state.nb_dc[5]) : item.intra_mb;
        res.predicted_count = -6'sd1;
      end
      cavlc_nc_pkg::BT_CHROMA_AC: begin
        la = chr_l_ext[item.block_index[1:0]] ? item.left_available : 1'b1;
        ta = chr_t_ext[item.block_index[1:0]] ? item.top_available : 1'b1;
        na = chr_l_cnt[slot];
        nb = chr_t_cnt[slot];
        res.coded_flag_left = la ? (|na) : item.intra_mb;
        res.coded_flag_top  = ta ? (|nb) : item.intra_mb;
        res.predicted_count = {1'b0, cavlc_nc_pkg::mean_nc(la, ta, na, nb)};
      end
      default: begin
        la = luma_l_ext[blk] ? item.left_available : 1'b1;
        ta = luma_t_ext[blk] ? item.top_available : 1'b1;
        na = luma_l_cnt[blk];
        nb = luma_t_cnt[blk];
        if (item.block_type == cavlc_nc_pkg::BT_LUMA_DC) begin
          res.coded_flag_left = item.left_available ? state.nb_dc[0] : item.intra_mb;
          res.coded_flag_top  = item.top_available ? state.nb_dc[4] : item.intra_mb;
        end else begin
          res.coded_flag_left = la ? (|na) : item.intra_mb;
          res.coded_flag_top  = ta ? (|nb) : item.intra_mb;
        end
        res.predicted_count = {1'b0, cavlc_nc_pkg::mean_nc(la, ta, na, nb)};
      end
    endcase
    if (item.command != cavlc_nc_pkg::CMD_QUERY) res = '0;
  end

endmodule

FILE: rtl/cavlc_neighbor_count_predictor_unit.sv
// cavlc neighbour count predictor
// keeps the nonzero coefficient counts of one macroblock and predicts nC
// for the cavlc coeff_token table choice of each 4x4 block
// input channel in_*: one item per command; in_tuser selects the command
// (start macroblock, query, record) and the block type, in_tdata carries
// the block index, availability, counts and neighbour dc flags
// result channel out_*: exactly one item per input item, in order, with
// the coded flags, nC (-1 for chroma dc) and the current dc flags
// out_tvalid rises once the accepted item has passed the input register
// and then the result register; throughput one item per cycle while the
// receiver keeps out_tready high, since all work for an item is one
// combinational pass between those two registers
// reset clears all counts, neighbour stores and dc flags and empties
// both registers
// when the receiver stalls the result register holds; the input register
// takes one more item only if it is empty, then in_tready drops until the result moves
module cavlc_neighbor_count_predictor_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // block_index, intra_mb, left_available, top_available, coeff_cnt,
  // left_luma_counts, top_luma_counts, chroma_neighbor_counts, neighbor_dc_flags
  input  logic [cavlc_nc_pkg::IN_DATA_W-1:0]    in_tdata,
  // command, block_type
  input  logic [cavlc_nc_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // coded_flag_left, coded_flag_top, predicted_count, current_dc_flags
  output logic [cavlc_nc_pkg::OUT_DATA_W-1:0]   out_tdata
);

  cavlc_nc_pkg::item_t  item_in;
  cavlc_nc_pkg::item_t  item_r;
  cavlc_nc_pkg::state_t state;
  cavlc_nc_pkg::query_t res;
  logic [2:0]           dc_nxt;
  logic                 in_valid_r;
  logic                 out_valid_r;
  logic [cavlc_nc_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                 advance;
  logic                 upd_en;

  always_comb begin
    item_in.command                = in_tuser[1:0];
    item_in.block_type             = in_tuser[3:2];
    item_in.block_index            = in_tdata[3:0];
    item_in.intra_mb               = in_tdata[4];
    item_in.left_available         = in_tdata[5];
    item_in.top_available          = in_tdata[6];
    item_in.coeff_cnt              = in_tdata[11:7];
    item_in.left_luma_counts       = in_tdata[31:12];
    item_in.top_luma_counts        = in_tdata[51:32];
    item_in.chroma_neighbor_counts = in_tdata[91:52];
    item_in.neighbor_dc_flags      = in_tdata[99:92];
  end

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign upd_en    = advance && in_valid_r;

  cavlc_nc_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (upd_en),
    .item   (item_r),
    .state  (state),
    .dc_nxt (dc_nxt)
  );

  cavlc_nc_pred u_pred (
    .item  (item_r),
    .state (state),
    .res   (res)
  );

  assign out_data_nxt = {5'b0, dc_nxt, res.predicted_count,
                         res.coded_flag_top, res.coded_flag_left};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance)   out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) item_r <= item_in;
    if (upd_en) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/cavlc_nc_checker.sv
`include "assert_macros.svh"

module cavlc_nc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [cavlc_nc_pkg::OUT_DATA_W-1:0] out_tdata
);

  // stalled result item holds
  `CNC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // a ready receiver never back-pressures the input
  `CNC_ASSERT_IMP(a_in_ready, clk, rst_n, out_tready, in_tready)
  // with the receiver ready, an accepted item reaches out_tvalid through both registers
  `CNC_ASSERT_NXT(a_latency, clk, rst_n, (in_tvalid && in_tready && out_tready) ##1 out_tready, out_tvalid)
  // reset empties the result register
  `CNC_ASSERT_NXT_ALWAYS(a_reset, clk, !rst_n, !out_tvalid)

endmodule

bind cavlc_neighbor_count_predictor_unit cavlc_nc_checker u_cavlc_nc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
